// ===== rtl/lgrs_pkg.sv =====
// ----------------------------------------------------------------------------
// Life generation row step - shared definitions
// Row geometry, cell commands and the tap struct passed between cells.
// ----------------------------------------------------------------------------
package lgrs_pkg;

   localparam int ROW_W     = 64;
   localparam int MAX_WIDTH = 64;
   localparam int WIDTH_W   = 7;

   localparam logic [WIDTH_W-1:0] GRID_WIDTH_RESET = WIDTH_W'(64);

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_CLEAR,
      OP_LOAD,
      OP_SHIFT
   } cell_op_type;

   typedef struct packed {
      logic upper;
      logic middle;
      logic below;
   } cell_tap_type;

endpackage

// ===== rtl/lgrs_if.sv =====
// ----------------------------------------------------------------------------
// Life generation row step - channel interfaces
// Valid/ready channels for rows in, result rows out and the width register.
// ----------------------------------------------------------------------------
interface lgrs_req_if import lgrs_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ROW_W-1:0] row_cells;
   logic             first_row;
   logic             end_of_grid;

   modport source (output valid, row_cells, first_row, end_of_grid, input ready);
   modport sink   (input valid, row_cells, first_row, end_of_grid, output ready);
endinterface

interface lgrs_rsp_if import lgrs_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ROW_W-1:0] next_row;
   logic             last_row;

   modport source (output valid, next_row, last_row, input ready);
   modport sink   (input valid, next_row, last_row, output ready);
endinterface

interface lgrs_csr_if import lgrs_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [WIDTH_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/lgrs_cell.sv =====
// ----------------------------------------------------------------------------
// Life generation row step - column cell
// Holds one column of the upper and middle rows and computes its next state
// from its own bits and the taps of its left and right neighbors.
// ----------------------------------------------------------------------------
module lgrs_cell import lgrs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cell_op_type  op,
   input  logic         col_valid,
   input  logic         below,
   input  cell_tap_type left_tap,
   input  cell_tap_type right_tap,
   output cell_tap_type tap,
   output logic         next_bit
);

   logic upper_ff, upper_in;
   logic middle_ff, middle_in;
   logic [3:0] count;

   always_comb begin
      upper_in  = upper_ff;
      middle_in = middle_ff;
      case (op)
         OP_CLEAR: begin
            upper_in  = 1'b0;
            middle_in = 1'b0;
         end
         OP_LOAD: begin
            upper_in  = 1'b0;
            middle_in = below;
         end
         OP_SHIFT: begin
            upper_in  = middle_ff;
            middle_in = below;
         end
         default: begin
            upper_in  = upper_ff;
            middle_in = middle_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff  <= 1'b0;
         middle_ff <= 1'b0;
      end else begin
         upper_ff  <= upper_in;
         middle_ff <= middle_in;
      end
   end

   assign tap = '{upper: upper_ff, middle: middle_ff, below: below};

   assign count = {3'b000, left_tap.upper}  + {3'b000, upper_ff}  + {3'b000, right_tap.upper}
                + {3'b000, left_tap.middle} + {3'b000, right_tap.middle}
                + {3'b000, left_tap.below}  + {3'b000, below}     + {3'b000, right_tap.below};

   assign next_bit = col_valid & ((count == 4'd3) | (middle_ff & (count == 4'd2)));

endmodule

// ===== rtl/life_generation_row_step_top.sv =====
// ----------------------------------------------------------------------------
// Life generation row step - top level
// One Life generation (born on three, survive on two or three) over a grid
// streamed one row per word.
// ----------------------------------------------------------------------------
// Usage:
//   req_port carries one grid row per word; first_row opens a grid and
//   end_of_grid closes it (row_cells is then ignored). rsp_port returns the
//   next generation of the row above each row after the first, and of the
//   bottom row on the closing word, with last_row set.
//   csr_port writes grid_width (columns at or above it are dead); write it
//   only while no word is in flight. csr_port is always ready.
//   A result is registered and shows in the cycle after the word that causes
//   it is accepted. Throughput: one word per cycle while rsp_port is not
//   stalled, set by the row of column cells that all update in the same cycle.
//   A stalled rsp_port holds its word; req_port stays ready as long as the
//   output register is empty or drains in that cycle.
//   Reset clears the held rows, closes any open grid and sets the width to 64.
// ----------------------------------------------------------------------------
module life_generation_row_step_top import lgrs_pkg::*; (
   input  logic  clock,
   input  logic  reset,
   lgrs_req_if.sink   req_port,
   lgrs_rsp_if.source rsp_port,
   lgrs_csr_if.sink   csr_port
);

   logic [WIDTH_W-1:0] grid_width_ff;
   logic               have_middle_ff, have_middle_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0]   next_row_ff;
   logic               last_row_ff;

   logic               accept;
   logic               emit;
   cell_op_type        op;
   logic [ROW_W-1:0]   result_row;

   assign req_port.ready = !rsp_valid_ff || rsp_port.ready;
   assign csr_port.ready = 1'b1;
   assign accept         = req_port.valid && req_port.ready;

   always_comb begin
      op             = OP_HOLD;
      emit           = 1'b0;
      have_middle_in = have_middle_ff;
      if (accept) begin
         if (req_port.end_of_grid) begin
            op             = OP_CLEAR;
            emit           = have_middle_ff;
            have_middle_in = 1'b0;
         end else if (req_port.first_row || !have_middle_ff) begin
            op             = OP_LOAD;
            have_middle_in = 1'b1;
         end else begin
            op   = OP_SHIFT;
            emit = 1'b1;
         end
      end
   end

   cell_tap_type taps [MAX_WIDTH];

   genvar i;
   generate
      for (i = 0; i < ROW_W; i++) begin : g_col
         if (i < MAX_WIDTH) begin : g_cell
            logic         col_valid;
            logic         below;
            cell_tap_type left_tap;
            cell_tap_type right_tap;

            assign col_valid = WIDTH_W'(i) < grid_width_ff;
            assign below     = req_port.row_cells[i] & col_valid & !req_port.end_of_grid;

            if (i == 0) begin : g_left_edge
               assign left_tap = '0;
            end else begin : g_left
               assign left_tap = taps[i-1];
            end

            if (i == MAX_WIDTH - 1) begin : g_right_edge
               assign right_tap = '0;
            end else begin : g_right
               assign right_tap = taps[i+1];
            end

            lgrs_cell u_cell (
               .clock     (clock),
               .reset     (reset),
               .op        (op),
               .col_valid (col_valid),
               .below     (below),
               .left_tap  (left_tap),
               .right_tap (right_tap),
               .tap       (taps[i]),
               .next_bit  (result_row[i])
            );
         end else begin : g_dead
            assign result_row[i] = 1'b0;
         end
      end
   endgenerate

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= GRID_WIDTH_RESET;
         have_middle_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_port.valid) begin
            grid_width_ff <= csr_port.data;
         end
         have_middle_ff <= have_middle_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         next_row_ff <= result_row;
         last_row_ff <= req_port.end_of_grid;
      end
   end

   assign rsp_port.valid    = rsp_valid_ff;
   assign rsp_port.next_row = next_row_ff;
   assign rsp_port.last_row = last_row_ff;

endmodule

// ===== rtl/lgrs_checker.sv =====
// ----------------------------------------------------------------------------
// Life generation row step - port checker
// Watches the top-level channels: stalled results hold, last_row marking, silent first rows.
// ----------------------------------------------------------------------------
module lgrs_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_first_row,
   input logic req_end_of_grid,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_last_row
);

   logic req_take;

   assign req_take = req_valid && req_ready;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_end_last: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_end_of_grid) |=> (!rsp_valid || rsp_last_row))
      else $error("closing word gave a result without last_row");

   a_row_not_last: assert property (@(posedge clock) disable iff (reset)
      (req_take && !req_end_of_grid) |=> (!rsp_valid || !rsp_last_row))
      else $error("row word gave a result marked last_row");

   a_first_silent: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_first_row && !req_end_of_grid) |=> !rsp_valid)
      else $error("first row of a grid gave a result");

endmodule

bind life_generation_row_step_top lgrs_checker u_lgrs_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_port.valid),
   .req_ready       (req_port.ready),
   .req_first_row   (req_port.first_row),
   .req_end_of_grid (req_port.end_of_grid),
   .rsp_valid       (rsp_port.valid),
   .rsp_ready       (rsp_port.ready),
   .rsp_last_row    (rsp_port.last_row)
);

// ===== tb/tb_life_generation_row_step_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Life generation row step - testbench
// Streams directed and random grids through req_port, predicts each next
// generation row in the bench and compares every rsp_port word against it,
// across several grid widths and sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module tb_life_generation_row_step_top;
   import lgrs_pkg::*;

   localparam int QUIET_LIMIT = 3000;
   localparam int LONG_HOLD   = 300;

   typedef struct {
      logic [ROW_W-1:0] cells;
      logic             first;
      logic             closing;
   } row_word_type;

   typedef struct {
      logic [ROW_W-1:0] next_row;
      logic             last_row;
   } gen_row_type;

   logic clock;
   logic reset;

   lgrs_req_if req_bus ();
   lgrs_rsp_if rsp_bus ();
   lgrs_csr_if csr_bus ();

   life_generation_row_step_top uut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .csr_port (csr_bus)
   );

   row_word_type     pending_rows [$];
   gen_row_type      next_gen_rows [$];
   row_word_type     offer_word;
   gen_row_type      seen_row;
   logic [ROW_W-1:0] upper_cells;
   logic [ROW_W-1:0] middle_cells;
   logic             middle_held;
   logic [WIDTH_W-1:0] width_setting;
   int               words_queued;
   int               words_taken;
   int               send_idle_pct;
   int               recv_idle_pct;
   int               mismatch_count;
   int               rows_seen;
   int               hold_left;
   int               quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [ROW_W-1:0] grid_mask();
      int w;
      w = (width_setting > MAX_WIDTH) ? MAX_WIDTH : width_setting;
      if (w >= ROW_W) return '1;
      return (ROW_W'(1) << w) - ROW_W'(1);
   endfunction

   function automatic logic [ROW_W-1:0] life_rule_row(input logic [ROW_W-1:0] above,
                                                      input logic [ROW_W-1:0] here,
                                                      input logic [ROW_W-1:0] below);
      logic [ROW_W-1:0] res;
      int n;
      res = '0;
      for (int c = 0; c < MAX_WIDTH; c++) begin
         n = 0;
         for (int d = -1; d <= 1; d++) begin
            if (c + d >= 0 && c + d < ROW_W) begin
               n = n + int'(above[c+d]);
               n = n + int'(below[c+d]);
               if (d != 0) n = n + int'(here[c+d]);
            end
         end
         res[c] = here[c] ? (n == 2 || n == 3) : (n == 3);
      end
      return res & grid_mask();
   endfunction

   function automatic void advance_life_grid(input logic [ROW_W-1:0] cells,
                                             input logic first, input logic closing);
      logic [ROW_W-1:0] row;
      gen_row_type g;
      row = cells & grid_mask();
      if (closing) begin
         if (middle_held) begin
            g.next_row = life_rule_row(upper_cells, middle_cells, '0);
            g.last_row = 1'b1;
            next_gen_rows.push_back(g);
         end
         upper_cells  = '0;
         middle_cells = '0;
         middle_held  = 1'b0;
      end else if (first || !middle_held) begin
         upper_cells  = '0;
         middle_cells = row;
         middle_held  = 1'b1;
      end else begin
         g.next_row = life_rule_row(upper_cells, middle_cells, row);
         g.last_row = 1'b0;
         next_gen_rows.push_back(g);
         upper_cells  = middle_cells;
         middle_cells = row;
      end
   endfunction

   // drive req_port from the pending queue
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            advance_life_grid(req_bus.row_cells, req_bus.first_row, req_bus.end_of_grid);
            words_taken++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_rows.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               offer_word = pending_rows.pop_front();
               req_bus.row_cells   <= offer_word.cells;
               req_bus.first_row   <= offer_word.first;
               req_bus.end_of_grid <= offer_word.closing;
               req_bus.valid       <= 1'b1;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // check rsp_port words and drive its ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            rows_seen++;
            if (rows_seen == 200 || rows_seen == 900) hold_left = LONG_HOLD;
            if (next_gen_rows.size() == 0) begin
               $display("%0t: unexpected word next_row=%h last_row=%b", $time,
                        rsp_bus.next_row, rsp_bus.last_row);
               mismatch_count++;
            end else begin
               seen_row = next_gen_rows.pop_front();
               if (rsp_bus.next_row !== seen_row.next_row) begin
                  $display("%0t: next_row expected %h actual %h", $time,
                           seen_row.next_row, rsp_bus.next_row);
                  mismatch_count++;
               end
               if (rsp_bus.last_row !== seen_row.last_row) begin
                  $display("%0t: last_row expected %b actual %b", $time,
                           seen_row.last_row, rsp_bus.last_row);
                  mismatch_count++;
               end
            end
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic add_word(input logic [ROW_W-1:0] cells, input logic first,
                           input logic closing);
      row_word_type w;
      w.cells   = cells;
      w.first   = first;
      w.closing = closing;
      pending_rows.push_back(w);
      words_queued++;
   endtask

   function automatic logic [ROW_W-1:0] random_row();
      logic [ROW_W-1:0] r;
      r = {$urandom, $urandom};
      case ($urandom_range(4))
         0: r = r & {$urandom, $urandom};
         1: r = r | {$urandom, $urandom};
         2: if ($urandom_range(3) == 0) r = '1;
         default: ;
      endcase
      return r;
   endfunction

   task automatic add_grid(input int rows, input bit closed);
      add_word(random_row(), 1'b1, 1'b0);
      for (int i = 1; i < rows; i++) add_word(random_row(), 1'b0, 1'b0);
      if (closed) add_word(random_row(), 1'($urandom_range(1)), 1'b1);
   endtask

   task automatic wait_drained();
      while (words_taken != words_queued || next_gen_rows.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_grid_width(input int w);
      wait_drained();
      @(posedge clock);
      csr_bus.data  <= WIDTH_W'(w);
      csr_bus.valid <= 1'b1;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      width_setting = WIDTH_W'(w);
   endtask

   task automatic fill_segment(input int count);
      int stop;
      int r;
      stop = words_queued + count;
      while (words_queued < stop) begin
         r = $urandom_range(99);
         if (r < 85)      add_grid($urandom_range(1, 10), 1'b1);
         else if (r < 89) add_grid($urandom_range(1, 4), 1'b0);
         else if (r < 92) add_word(random_row(), 1'($urandom_range(1)), 1'b1);
         else if (r < 96) add_word(random_row(), 1'b0, 1'b0);
         else             add_word(random_row(), 1'b1, 1'b0);
      end
   endtask

   int seg_width [12] = '{1, 0, 127, 65, 3, 64, 8, 63, 2, 33, 64, 5};
   int w;

   initial begin
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.row_cells   = '0;
      req_bus.first_row   = 1'b0;
      req_bus.end_of_grid = 1'b0;
      rsp_bus.ready       = 1'b0;
      csr_bus.valid       = 1'b0;
      csr_bus.data        = '0;
      upper_cells         = '0;
      middle_cells        = '0;
      middle_held         = 1'b0;
      width_setting       = GRID_WIDTH_RESET;
      words_queued        = 0;
      words_taken         = 0;
      mismatch_count      = 0;
      rows_seen           = 0;
      hold_left           = 0;
      quiet_cycles        = 0;
      send_idle_pct       = 22;
      recv_idle_pct       = 80;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      add_word('1, 1'b1, 1'b0);
      add_word('1, 1'b0, 1'b0);
      add_word('1, 1'b0, 1'b0);
      add_word('0, 1'b0, 1'b1);
      add_word('1, 1'b0, 1'b1);
      add_word('1, 1'b1, 1'b1);
      add_word(64'h8000_0000_0000_0001, 1'b1, 1'b0);
      add_word('1, 1'b1, 1'b1);
      add_word(64'h7, 1'b0, 1'b0);
      add_word(64'h7, 1'b0, 1'b0);
      add_word(64'h7, 1'b0, 1'b0);
      add_word('0, 1'b0, 1'b1);
      add_word(64'h5, 1'b1, 1'b0);
      add_word(64'h38, 1'b1, 1'b0);
      add_word(64'h38, 1'b0, 1'b0);
      add_word(64'h38, 1'b0, 1'b0);
      add_word('0, 1'b0, 1'b1);
      add_word(64'h8000_0000_0000_0003, 1'b1, 1'b0);
      add_word(64'hC000_0000_0000_0001, 1'b0, 1'b0);
      add_word('0, 1'b0, 1'b1);
      add_word(64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b0);
      add_word(64'h5555_5555_5555_5555, 1'b0, 1'b0);
      add_word('0, 1'b0, 1'b1);

      for (int seg = 0; seg < 12; seg++) begin
         w = (seg == 11) ? $urandom_range(127) : seg_width[seg];
         write_grid_width(w);
         if (seg == 4) begin
            send_idle_pct = 80;
            recv_idle_pct = 22;
         end else if (seg == 8) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         fill_segment(117);
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (next_gen_rows.size() != 0) begin
         $display("%0t: %0d expected rows never arrived", $time, next_gen_rows.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/lgrs_pkg.sv
rtl/lgrs_if.sv
rtl/lgrs_cell.sv
rtl/life_generation_row_step_top.sv
rtl/lgrs_checker.sv
tb/tb_life_generation_row_step_top.sv
